[hdl/tlpq_pkg.sv]
// ---------------------------------------------------------------------------
// tlpq_pkg
// Shared types and constants for the three-level priority ticket queue.
// ---------------------------------------------------------------------------
package tlpq_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int MAX_LIST        = 16;

    localparam logic [2:0] CMD_REGISTER = 3'd0;
    localparam logic [2:0] CMD_SET_PRIO = 3'd1;
    localparam logic [2:0] CMD_SERVE    = 3'd2;
    localparam logic [2:0] CMD_FIND     = 3'd3;
    localparam logic [2:0] CMD_LIST     = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BAD_LEVEL = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    localparam logic [1:0] LEVEL_NONE = 2'd0;
    localparam logic [1:0] LEVEL_LOW  = 2'd1;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture command word, clear scan state
        logic scan_clr;   // clear scan state only (next list pass)
        logic scan_step;  // examine one slot
        logic commit;     // apply table update for the command
        logic emit;       // drive result
        logic emit_err;   // result is an error with given status
        logic [2:0] err;
        logic emit_last;
        logic mark_best;  // mark best slot as taken (list)
    } tlpq_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic [2:0] cmd;
        logic found;
        logic has_free;
        logic any_valid;
        logic best_ok;
        logic level_zero;
        logic list_end;   // all list entries emitted after this one
    } tlpq_sts_t;

endpackage

[hdl/three_level_priority_ticket_queue_core.sv]
// ---------------------------------------------------------------------------
// three_level_priority_ticket_queue_core
// Priority ticket table with register, set priority, serve, find and list.
//
// channel   signals                                    handshake
// command   cmd, ticket_id, level                      start & !busy
// result    status, entry_id, entry_level,             strobe (one cycle)
//           entry_arrival, last
//
// A command runs one scan of the table, one slot a cycle, then decision and
// the result word. List rescans the table for every word that it emits.
// Reset clears all valid marks and the arrival counter at once.
// Results are never stalled; busy holds off new commands.
// ---------------------------------------------------------------------------
module three_level_priority_ticket_queue_core #(
    parameter int TABLE_DEPTH = tlpq_pkg::DEF_TABLE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] ticket_id,
    input  logic [1:0]         level,
    output logic               strobe,
    output logic [2:0]         status,
    output logic signed [31:0] entry_id,
    output logic [1:0]         entry_level,
    output logic [31:0]        entry_arrival,
    output logic               last
);
    import tlpq_pkg::*;

    tlpq_ctl_t ctl;
    tlpq_sts_t sts;

    tlpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    tlpq_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .ticket_id     (ticket_id),
        .level         (level),
        .ctl           (ctl),
        .sts           (sts),
        .strobe        (strobe),
        .status        (status),
        .entry_id      (entry_id),
        .entry_level   (entry_level),
        .entry_arrival (entry_arrival),
        .last          (last)
    );

endmodule

[hdl/tlpq_datapath.sv]
// ---------------------------------------------------------------------------
// tlpq_datapath
// Slot table, arrival counter and a one-slot-per-cycle scan unit.
// ---------------------------------------------------------------------------
module tlpq_datapath #(
    parameter int TABLE_DEPTH = tlpq_pkg::DEF_TABLE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          cmd,
    input  logic signed [31:0]  ticket_id,
    input  logic [1:0]          level,
    input  tlpq_pkg::tlpq_ctl_t ctl,
    output tlpq_pkg::tlpq_sts_t sts,
    output logic                strobe,
    output logic [2:0]          status,
    output logic signed [31:0]  entry_id,
    output logic [1:0]          entry_level,
    output logic [31:0]         entry_arrival,
    output logic                last
);
    import tlpq_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = $clog2(MAX_LIST + 1);

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] taken_reg;
    logic [31:0] id_mem  [TABLE_DEPTH];
    logic [1:0]  lvl_mem [TABLE_DEPTH];
    logic [31:0] arr_mem [TABLE_DEPTH];
    logic [31:0] arrival_reg;

    logic [2:0]  cmd_reg;
    logic [31:0] id_reg;
    logic [1:0]  lvl_reg;

    logic [CW-1:0] scan_reg;
    logic          found_reg, free_ok_reg, best_ok_reg;
    logic [IW-1:0] found_idx_reg, free_idx_reg, best_idx_reg;
    logic [1:0]    best_lvl_reg;
    logic [31:0]   best_arr_reg;
    logic [CW-1:0] count_reg;
    logic [LW-1:0] emitted_reg;

    logic [IW-1:0] si;
    logic          sv, better;
    logic [IW-1:0] sel;

    assign si = scan_reg[IW-1:0];
    assign sv = valid_reg[si];
    assign better = !best_ok_reg || (lvl_mem[si] > best_lvl_reg) ||
                    ((lvl_mem[si] == best_lvl_reg) && (arr_mem[si] < best_arr_reg));

    always_comb
    begin
        sel = best_idx_reg;
        unique case (cmd_reg)
            CMD_REGISTER: sel = free_idx_reg;
            CMD_SET_PRIO: sel = found_idx_reg;
            CMD_FIND:     sel = found_idx_reg;
            default:      sel = best_idx_reg;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.commit && cmd_reg == CMD_REGISTER)
            valid_next[free_idx_reg] = 1'b1;
        if (ctl.commit && cmd_reg == CMD_SERVE)
            valid_next[best_idx_reg] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            arrival_reg <= '0;
            taken_reg   <= '0;
            scan_reg    <= '0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
            best_ok_reg <= 1'b0;
            count_reg   <= '0;
            emitted_reg <= '0;
            strobe      <= 1'b0;
            cmd_reg     <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            strobe    <= ctl.emit;
            if (ctl.load || ctl.scan_clr)
            begin
                scan_reg    <= '0;
                found_reg   <= 1'b0;
                free_ok_reg <= 1'b0;
                best_ok_reg <= 1'b0;
                count_reg   <= '0;
            end
            else if (ctl.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (sv)
                    count_reg <= count_reg + 1'b1;
                if (sv && id_mem[si] == id_reg && !found_reg)
                begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= si;
                end
                if (!sv && !free_ok_reg)
                begin
                    free_ok_reg  <= 1'b1;
                    free_idx_reg <= si;
                end
                if (sv && !taken_reg[si] && better)
                begin
                    best_ok_reg  <= 1'b1;
                    best_idx_reg <= si;
                    best_lvl_reg <= lvl_mem[si];
                    best_arr_reg <= arr_mem[si];
                end
            end
            if (ctl.load)
            begin
                cmd_reg     <= cmd;
                taken_reg   <= '0;
                emitted_reg <= '0;
            end
            if (ctl.mark_best)
            begin
                taken_reg[best_idx_reg] <= 1'b1;
                emitted_reg <= emitted_reg + 1'b1;
            end
            if (ctl.commit && cmd_reg == CMD_REGISTER)
                arrival_reg <= arrival_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            id_reg  <= ticket_id;
            lvl_reg <= level;
        end
        if (ctl.commit && cmd_reg == CMD_REGISTER)
        begin
            id_mem[free_idx_reg]  <= id_reg;
            lvl_mem[free_idx_reg] <= LEVEL_LOW;
            arr_mem[free_idx_reg] <= arrival_reg;
        end
        if (ctl.commit && cmd_reg == CMD_SET_PRIO)
            lvl_mem[found_idx_reg] <= lvl_reg;
        if (ctl.emit)
        begin
            last <= ctl.emit_last;
            if (ctl.emit_err)
            begin
                status        <= ctl.err;
                entry_id      <= '0;
                entry_level   <= LEVEL_NONE;
                entry_arrival <= '0;
            end
            else if (ctl.commit && cmd_reg == CMD_REGISTER)
            begin
                // table write lands on this edge: word comes from the new values
                status        <= ST_OK;
                entry_id      <= id_reg;
                entry_level   <= LEVEL_LOW;
                entry_arrival <= arrival_reg;
            end
            else
            begin
                status        <= ST_OK;
                entry_id      <= id_mem[sel];
                entry_level   <= (ctl.commit && cmd_reg == CMD_SET_PRIO) ? lvl_reg
                                                                          : lvl_mem[sel];
                entry_arrival <= arr_mem[sel];
            end
        end
    end

    always_comb
    begin
        sts.scan_done  = (scan_reg == CW'(TABLE_DEPTH));
        sts.cmd        = cmd_reg;
        sts.found      = found_reg;
        sts.has_free   = free_ok_reg;
        sts.any_valid  = (count_reg != '0);
        sts.best_ok    = best_ok_reg;
        sts.level_zero = (lvl_reg == LEVEL_NONE);
        sts.list_end   = ((32'(emitted_reg) + 32'd1) >= 32'(count_reg)) ||
                         ((32'(emitted_reg) + 32'd1) >= 32'(MAX_LIST));
    end

endmodule

[hdl/tlpq_ctrl.sv]
// ---------------------------------------------------------------------------
// tlpq_ctrl
// Command sequencer: scan, decide, commit, emit.
// ---------------------------------------------------------------------------
module tlpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tlpq_pkg::tlpq_sts_t sts,
    output tlpq_pkg::tlpq_ctl_t ctl
);
    import tlpq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0] state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_DONE;
                else
                    ctl.scan_step = 1'b1;
            end
            S_DONE:
            begin
                state_next = S_WAIT;
                ctl.emit = 1'b1;
                ctl.emit_last = 1'b1;
                priority case (sts.cmd)
                    CMD_REGISTER:
                    begin
                        if (sts.found)
                        begin
                            ctl.emit_err = 1'b1; ctl.err = ST_DUP;
                        end
                        else if (!sts.has_free)
                        begin
                            ctl.emit_err = 1'b1; ctl.err = ST_FULL;
                        end
                        else
                            ctl.commit = 1'b1;
                    end
                    CMD_SET_PRIO:
                    begin
                        if (!sts.found)
                        begin
                            ctl.emit_err = 1'b1; ctl.err = ST_NOT_FOUND;
                        end
                        else if (sts.level_zero)
                        begin
                            ctl.emit_err = 1'b1; ctl.err = ST_BAD_LEVEL;
                        end
                        else
                            ctl.commit = 1'b1;
                    end
                    CMD_SERVE:
                    begin
                        if (!sts.best_ok)
                        begin
                            ctl.emit_err = 1'b1; ctl.err = ST_EMPTY;
                        end
                        else
                            ctl.commit = 1'b1;
                    end
                    CMD_FIND:
                    begin
                        if (!sts.any_valid)
                        begin
                            ctl.emit_err = 1'b1; ctl.err = ST_EMPTY;
                        end
                        else if (!sts.found)
                        begin
                            ctl.emit_err = 1'b1; ctl.err = ST_NOT_FOUND;
                        end
                    end
                    CMD_LIST:
                    begin
                        if (!sts.best_ok)
                        begin
                            ctl.emit_err = 1'b1; ctl.err = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.emit_last = sts.list_end;
                            ctl.mark_best = 1'b1;
                            if (!sts.list_end)
                            begin
                                ctl.scan_clr = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    default:
                    begin
                        ctl.emit = 1'b0;
                        ctl.emit_last = 1'b0;
                    end
                endcase
            end
            S_WAIT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hdl/tlpq_checker.sv]
// ---------------------------------------------------------------------------
// tlpq_port_checks
// Port-level checks on the ticket queue.
// ---------------------------------------------------------------------------
module tlpq_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic [2:0]  status,
    input logic [1:0]  entry_level,
    input logic        last
);
    import tlpq_pkg::*;

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != ST_OK |-> last)
        else $error("error word without last");

    a_err_level: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != ST_OK |-> entry_level == LEVEL_NONE)
        else $error("error word with level");

    a_ok_level: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == ST_OK |-> entry_level != LEVEL_NONE)
        else $error("ok word without level");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !strobe)
        else $error("word while idle");

endmodule

bind three_level_priority_ticket_queue_core tlpq_port_checks u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .strobe      (strobe),
    .status      (status),
    .entry_level (entry_level),
    .last        (last)
);

[tb/tlpq_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlpq_checker
// Watches the command and result channels of the ticket queue, keeps its own
// copy of the table, and compares every result word with the predicted one.
// ---------------------------------------------------------------------------
module tlpq_checker
    import tlpq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] ticket_id,
    input  logic [1:0]         level,
    input  logic               strobe,
    input  logic [2:0]         status,
    input  logic signed [31:0] entry_id,
    input  logic [1:0]         entry_level,
    input  logic [31:0]        entry_arrival,
    input  logic               last,
    output int                 fail_count,
    output int                 pending
);

    localparam int DEPTH = DEF_TABLE_DEPTH;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] id;
        logic [1:0]  lvl;
        logic [31:0] arr;
        logic        last;
    } word_t;

    word_t       want_q[$];
    logic        t_valid [DEPTH];
    logic [31:0] t_id    [DEPTH];
    logic [1:0]  t_lvl   [DEPTH];
    logic [31:0] t_arr   [DEPTH];
    logic [31:0] arr_cnt;

    assign pending = want_q.size();

    function automatic word_t err_word(logic [2:0] st);
        word_t w;
        w = '0;
        w.status = st;
        w.last = 1'b1;
        return w;
    endfunction

    function automatic word_t slot_word(int s, logic lst);
        word_t w;
        w.status = ST_OK;
        w.id = t_id[s];
        w.lvl = t_lvl[s];
        w.arr = t_arr[s];
        w.last = lst;
        return w;
    endfunction

    function automatic int lookup(logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (t_valid[i] && t_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int best_slot(logic taken [DEPTH]);
        int b;
        b = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!t_valid[i] || taken[i])
                continue;
            if (b < 0 || t_lvl[i] > t_lvl[b] ||
                (t_lvl[i] == t_lvl[b] && t_arr[i] < t_arr[b]))
                b = i;
        end
        return b;
    endfunction

    task automatic predict_command(logic [2:0] c, logic [31:0] id, logic [1:0] lv);
        int s;
        int n;
        logic taken [DEPTH];
        for (int i = 0; i < DEPTH; i++)
            taken[i] = 1'b0;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (t_valid[i])
                n++;
        case (c)
            CMD_REGISTER:
            begin
                s = -1;
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (!t_valid[i])
                        s = i;
                if (lookup(id) >= 0)
                    want_q.push_back(err_word(ST_DUP));
                else if (s < 0)
                    want_q.push_back(err_word(ST_FULL));
                else
                begin
                    t_valid[s] = 1'b1;
                    t_id[s] = id;
                    t_lvl[s] = LEVEL_LOW;
                    t_arr[s] = arr_cnt;
                    arr_cnt++;
                    want_q.push_back(slot_word(s, 1'b1));
                end
            end
            CMD_SET_PRIO:
            begin
                s = lookup(id);
                if (s < 0)
                    want_q.push_back(err_word(ST_NOT_FOUND));
                else if (lv == LEVEL_NONE)
                    want_q.push_back(err_word(ST_BAD_LEVEL));
                else
                begin
                    t_lvl[s] = lv;
                    want_q.push_back(slot_word(s, 1'b1));
                end
            end
            CMD_SERVE:
            begin
                s = best_slot(taken);
                if (s < 0)
                    want_q.push_back(err_word(ST_EMPTY));
                else
                begin
                    want_q.push_back(slot_word(s, 1'b1));
                    t_valid[s] = 1'b0;
                end
            end
            CMD_FIND:
            begin
                s = lookup(id);
                if (n == 0)
                    want_q.push_back(err_word(ST_EMPTY));
                else if (s < 0)
                    want_q.push_back(err_word(ST_NOT_FOUND));
                else
                    want_q.push_back(slot_word(s, 1'b1));
            end
            CMD_LIST:
            begin
                if (n == 0)
                    want_q.push_back(err_word(ST_EMPTY));
                if (n > MAX_LIST)
                    n = MAX_LIST;
                for (int k = 0; k < n; k++)
                begin
                    s = best_slot(taken);
                    taken[s] = 1'b1;
                    want_q.push_back(slot_word(s, k == n - 1));
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        word_t got;
        word_t w;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                t_valid[i] = 1'b0;
            arr_cnt = '0;
            want_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (strobe)
            begin
                got = {status, entry_id, entry_level, entry_arrival, last};
                if (want_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word %h", got);
                end
                else
                begin
                    w = want_q.pop_front();
                    if (got !== w)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp st=%0d id=%h lvl=%0d arr=%0d last=%b, got st=%0d id=%h lvl=%0d arr=%0d last=%b",
                                w.status, w.id, w.lvl, w.arr, w.last,
                                got.status, got.id, got.lvl, got.arr, got.last);
                    end
                end
            end
            if (start && !busy)
                predict_command(cmd, ticket_id, level);
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives directed and random commands into the ticket queue with random gaps,
// and reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module tb;
    import tlpq_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         cmd;
    logic signed [31:0] ticket_id;
    logic [1:0]         level;
    logic               strobe;
    logic [2:0]         status;
    logic signed [31:0] entry_id;
    logic [1:0]         entry_level;
    logic [31:0]        entry_arrival;
    logic               last;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    logic [31:0]        id_pool [8];

    three_level_priority_ticket_queue_core u_top (.*);

    tlpq_checker u_chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (start && !busy || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // start stays high after an accept when the next word follows with no gap
    task automatic send_word(logic [2:0] c, logic [31:0] id, logic [1:0] lv);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        ticket_id <= id;
        level <= lv;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_random;
        int r;
        logic [31:0] id;
        logic [2:0] c;
        r = $urandom_range(0, 99);
        id = ($urandom_range(0, 3) == 0) ? $urandom() : id_pool[$urandom_range(0, 7)];
        if (r < 30)
            c = CMD_REGISTER;
        else if (r < 50)
            c = CMD_SET_PRIO;
        else if (r < 70)
            c = CMD_SERVE;
        else if (r < 85)
            c = CMD_FIND;
        else if (r < 95)
            c = CMD_LIST;
        else
            c = 3'($urandom_range(5, 7));
        send_word(c, id, 2'($urandom_range(0, 3)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_REGISTER;
        ticket_id = '0;
        level = LEVEL_NONE;
        idle_cycles = 0;
        for (int i = 0; i < 8; i++)
            id_pool[i] = $urandom();
        id_pool[0] = 32'h8000_0000;
        id_pool[1] = 32'h7FFF_FFFF;
        id_pool[2] = 32'h0;
        id_pool[3] = 32'hFFFF_FFFF;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table cases
        send_word(CMD_SERVE, 0, LEVEL_NONE);
        send_word(CMD_FIND, 0, LEVEL_NONE);
        send_word(CMD_LIST, 0, LEVEL_NONE);
        send_word(CMD_SET_PRIO, 5, 2'd3);
        send_word(3'd7, 0, 2'd3);
        // fill to full, duplicate on full
        for (int i = 0; i < 16; i++)
            send_word(CMD_REGISTER, (i < 4) ? id_pool[i] : 32'(i * 977), LEVEL_NONE);
        send_word(CMD_REGISTER, 32'h1234_5678, LEVEL_NONE);
        send_word(CMD_REGISTER, id_pool[1], LEVEL_NONE);
        send_word(CMD_SET_PRIO, id_pool[0], LEVEL_NONE);
        send_word(CMD_SET_PRIO, id_pool[3], 2'd3);
        send_word(CMD_SET_PRIO, id_pool[2], 2'd2);
        send_word(CMD_FIND, 32'h5555_AAAA, LEVEL_NONE);
        send_word(CMD_FIND, id_pool[3], LEVEL_NONE);
        send_word(CMD_LIST, 0, LEVEL_NONE);

        for (int n = 0; n < 184; n++)
            send_random();
        for (int i = 0; i < 17; i++)
            send_word(CMD_SERVE, 0, LEVEL_NONE);
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/tlpq_pkg.sv
hdl/tlpq_datapath.sv
hdl/tlpq_ctrl.sv
hdl/three_level_priority_ticket_queue_core.sv
hdl/tlpq_checker.sv
tb/tlpq_checker.sv
tb/tb.sv
